/* rtl/itbs_pkg.sv */
`timescale 1ns / 1ps
package itbs_pkg;

	localparam int TILES_ACROSS_DFLT = 64;
	localparam int MAX_TILE_SIDE     = 64;
	localparam int MAX_IMAGE_SIDE    = 4096;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 12;
	localparam int SUM_W      = 20;
	localparam int TOTAL_W    = 32;
	localparam int IMG_REG_W  = 13;
	localparam int TILE_REG_W = 7;
	localparam int OFS_W      = $clog2(MAX_TILE_SIDE);
	localparam int RES_DEPTH  = 8;

	localparam logic [IMG_REG_W-1:0]  IMAGE_ROWS_RST = IMG_REG_W'(512);
	localparam logic [IMG_REG_W-1:0]  IMAGE_COLS_RST = IMG_REG_W'(512);
	localparam logic [TILE_REG_W-1:0] TILE_ROWS_RST  = TILE_REG_W'(8);
	localparam logic [TILE_REG_W-1:0] TILE_COLS_RST  = TILE_REG_W'(8);

	localparam logic [1:0] REG_IMAGE_ROWS = 2'd0;
	localparam logic [1:0] REG_IMAGE_COLS = 2'd1;
	localparam logic [1:0] REG_TILE_ROWS  = 2'd2;
	localparam logic [1:0] REG_TILE_COLS  = 2'd3;

	typedef struct packed {
		logic               is_total;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic [SUM_W-1:0]   tile_sum;
		logic [TOTAL_W-1:0] image_total;
		logic               last;
	} res_t;

	function automatic logic [IMG_REG_W-1:0] clamp_img(input logic [IMG_REG_W-1:0] v);
		logic [IMG_REG_W-1:0] r;
		if (v == '0) begin
			r = IMG_REG_W'(1);
		end else if (v > IMG_REG_W'(MAX_IMAGE_SIDE)) begin
			r = IMG_REG_W'(MAX_IMAGE_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [TILE_REG_W-1:0] clamp_tile(input logic [TILE_REG_W-1:0] v);
		logic [TILE_REG_W-1:0] r;
		if (v == '0) begin
			r = TILE_REG_W'(1);
		end else if (v > TILE_REG_W'(MAX_TILE_SIDE)) begin
			r = TILE_REG_W'(MAX_TILE_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/itbs_ram.sv */
`timescale 1ns / 1ps
module itbs_ram import itbs_pkg::*; #(
	parameter int WIDTH = SUM_W,
	parameter int DEPTH = TILES_ACROSS_DFLT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/itbs_res_fifo.sv */
`timescale 1ns / 1ps
module itbs_res_fifo import itbs_pkg::*; #(
	parameter int DEPTH = RES_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  res_t          push_data0,
	input  res_t          push_data1,
	input  logic          pop_ready,
	output logic          out_valid,
	output res_t          out_data,
	output logic [CW-1:0] count
);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rp_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push_data0;
		end
		if (push_n == 2'd2) begin
			mem_q[PW'(wp_q + PW'(1))] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= PW'(wp_q + PW'(push_n));
			rp_q    <= PW'(rp_q + PW'(pop));
			count_q <= CW'(count_q + CW'(push_n) - CW'(pop));
		end
	end

endmodule

/* rtl/image_tile_block_sum.sv */
// Path: an accepted pixel is registered in stage s1; its results then enter the result queue.
// Throughput: one pixel per cycle while the queue has room; tile sums sit in a one-port-read,
// one-port-write RAM, with the last write forwarded so the same tile column can be hit on
// consecutive cycles. Two results from one pixel are pushed at once into the 8-entry queue.
// Reset (arst_n, asynchronous): registers to defaults, counters, totals, tile-sum valid bits
// and the queue clear at once; RAM contents are masked by the valid bits, so no clearing pass.
`timescale 1ns / 1ps
module image_tile_block_sum import itbs_pkg::*; #(
	parameter int MAX_TILES_ACROSS = TILES_ACROSS_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // pixel[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // center_row[11:0], center_col[23:12], tile_sum[43:24],
	                              // image_total[75:44], zero[79:76]
	output logic        m_tuser,  // is_total
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W  = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
	localparam int TIDX_W = $clog2(MAX_TILES_ACROSS + 1);
	localparam int CNT_W  = $clog2(RES_DEPTH + 1);

	logic [IMG_REG_W-1:0]  image_rows_q, image_cols_q;
	logic [TILE_REG_W-1:0] tile_rows_q, tile_cols_q;
	logic                  cfg_wr;

	logic [IMG_REG_W-1:0]  rows, cols;
	logic [TILE_REG_W-1:0] tr, tc;

	logic [COORD_W-1:0] row_q, col_q;
	logic [OFS_W-1:0]   rit_q, cit_q;
	logic [TIDX_W-1:0]  tidx_q;
	logic [TOTAL_W-1:0] total_q;

	logic [PIX_W-1:0]      px;
	logic                  accept;
	logic [13:0]           row_span, col_span;
	logic                  whole_row, whole_col, whole;
	logic [TILE_REG_W-1:0] rit_inc, cit_inc;
	logic                  rit_end, cit_end;
	logic                  end_row, end_img, emit;
	logic [COORD_W-1:0]    crow, ccol;
	logic [TOTAL_W-1:0]    sum_total;

	logic               valid_s1, whole_s1, emit_s1, end_img_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COORD_W-1:0] crow_s1, ccol_s1;
	logic [TOTAL_W-1:0] total_s1;

	logic [MAX_TILES_ACROSS-1:0] band_valid_q;
	logic                        wr_en_q;
	logic [IDX_W-1:0]            wr_addr_q;
	logic [SUM_W-1:0]            wr_data_q;

	logic [SUM_W-1:0] ram_rdata, base, new_sum, wr_data;
	logic             wr_en;

	res_t             tile_res, total_res, push_data0, out_res;
	logic [1:0]       push_n;
	logic [CNT_W-1:0] fifo_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= IMAGE_ROWS_RST;
			image_cols_q <= IMAGE_COLS_RST;
			tile_rows_q  <= TILE_ROWS_RST;
			tile_cols_q  <= TILE_COLS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_IMAGE_ROWS: image_rows_q <= pwdata[IMG_REG_W-1:0];
				REG_IMAGE_COLS: image_cols_q <= pwdata[IMG_REG_W-1:0];
				REG_TILE_ROWS:  tile_rows_q  <= pwdata[TILE_REG_W-1:0];
				REG_TILE_COLS:  tile_cols_q  <= pwdata[TILE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_ROWS: prdata = 32'(image_rows_q);
			REG_IMAGE_COLS: prdata = 32'(image_cols_q);
			REG_TILE_ROWS:  prdata = 32'(tile_rows_q);
			REG_TILE_COLS:  prdata = 32'(tile_cols_q);
			default:        prdata = '0;
		endcase
	end

	assign rows = clamp_img(image_rows_q);
	assign cols = clamp_img(image_cols_q);
	assign tr   = clamp_tile(tile_rows_q);
	assign tc   = clamp_tile(tile_cols_q);

	assign px     = s_tdata[PIX_W-1:0];
	assign accept = s_tvalid && s_tready;

	// tile start plus size, negative when the offset runs past the position
	assign row_span  = 14'(row_q) - 14'(rit_q) + 14'(tr);
	assign col_span  = 14'(col_q) - 14'(cit_q) + 14'(tc);
	assign whole_row = !row_span[13] && (row_span[12:0] <= rows);
	assign whole_col = (tidx_q < TIDX_W'(MAX_TILES_ACROSS)) && !col_span[13]
		&& (col_span[12:0] <= cols);
	assign whole     = whole_row && whole_col;

	assign rit_inc = TILE_REG_W'(rit_q) + TILE_REG_W'(1);
	assign cit_inc = TILE_REG_W'(cit_q) + TILE_REG_W'(1);
	assign rit_end = (rit_inc >= tr);
	assign cit_end = (cit_inc >= tc);

	assign end_row = (IMG_REG_W'(col_q) + IMG_REG_W'(1)) >= cols;
	assign end_img = end_row && ((IMG_REG_W'(row_q) + IMG_REG_W'(1)) >= rows);
	assign emit    = whole && rit_end && cit_end;

	assign crow      = row_q - COORD_W'(rit_q) + COORD_W'(tr >> 1);
	assign ccol      = col_q - COORD_W'(cit_q) + COORD_W'(tc >> 1);
	assign sum_total = total_q + TOTAL_W'(px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			rit_q   <= '0;
			cit_q   <= '0;
			tidx_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (end_img) begin
				row_q   <= '0;
				col_q   <= '0;
				rit_q   <= '0;
				cit_q   <= '0;
				tidx_q  <= '0;
				total_q <= '0;
			end else begin
				total_q <= sum_total;
				if (end_row) begin
					col_q  <= '0;
					cit_q  <= '0;
					tidx_q <= '0;
					row_q  <= COORD_W'(row_q + COORD_W'(1));
					rit_q  <= rit_end ? '0 : rit_inc[OFS_W-1:0];
				end else begin
					col_q <= COORD_W'(col_q + COORD_W'(1));
					if (cit_end) begin
						cit_q <= '0;
						if (tidx_q < TIDX_W'(MAX_TILES_ACROSS)) begin
							tidx_q <= TIDX_W'(tidx_q + TIDX_W'(1));
						end
					end else begin
						cit_q <= cit_inc[OFS_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= px;
			idx_s1     <= tidx_q[IDX_W-1:0];
			whole_s1   <= whole;
			emit_s1    <= emit;
			end_img_s1 <= end_img;
			crow_s1    <= crow;
			ccol_s1    <= ccol;
			total_s1   <= sum_total;
		end
	end

	itbs_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_TILES_ACROSS)
	) u_band_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_s1),
		.wdata(wr_data),
		.raddr(tidx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// forward the previous cycle's write, which the registered read missed
	always_comb begin
		if (!band_valid_q[idx_s1]) begin
			base = '0;
		end else if (wr_en_q && (wr_addr_q == idx_s1)) begin
			base = wr_data_q;
		end else begin
			base = ram_rdata;
		end
	end

	assign new_sum = base + SUM_W'(px_s1);
	assign wr_en   = valid_s1 && whole_s1;
	assign wr_data = emit_s1 ? '0 : new_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q      <= 1'b0;
			band_valid_q <= '0;
		end else begin
			wr_en_q <= wr_en;
			if (valid_s1 && end_img_s1) begin
				band_valid_q <= '0;
			end else if (wr_en) begin
				band_valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= idx_s1;
		wr_data_q <= wr_data;
	end

	always_comb begin
		tile_res             = '0;
		tile_res.center_row  = crow_s1;
		tile_res.center_col  = ccol_s1;
		tile_res.tile_sum    = new_sum;
		tile_res.last        = !end_img_s1;
		total_res            = '0;
		total_res.is_total   = 1'b1;
		total_res.image_total = total_s1;
		total_res.last       = 1'b1;
	end

	assign push_n     = valid_s1 ? (2'(emit_s1) + 2'(end_img_s1)) : 2'd0;
	assign push_data0 = emit_s1 ? tile_res : total_res;

	// leave room for the results in flight and for the two that the next pixel may give
	assign s_tready = ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(push_n) + (CNT_W + 1)'(2))
		<= (CNT_W + 1)'(RES_DEPTH);

	itbs_res_fifo #(
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data0(push_data0),
		.push_data1(total_res),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.count     (fifo_count)
	);

	assign m_tdata = {4'b0, out_res.image_total, out_res.tile_sum,
		out_res.center_col, out_res.center_row};
	assign m_tuser = out_res.is_total;
	assign m_tlast = out_res.last;

	a_emit_whole: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit_s1 |-> whole_s1)
		else $error("tile emitted without a whole tile");

	a_band_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && end_img_s1 |=> band_valid_q == '0)
		else $error("tile sums not cleared at end of image");

	a_image_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_img |=> (row_q == '0 && col_q == '0 && total_q == '0))
		else $error("position or total not cleared at end of image");

	a_tidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		tidx_q <= TIDX_W'(MAX_TILES_ACROSS))
		else $error("tile column index beyond limit");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> fifo_count <= CNT_W'(RES_DEPTH - 2))
		else $error("pixel taken without room for its results");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
	import itbs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // pixel[7:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;  // center_row[11:0], center_col[23:12], tile_sum[43:24],
	                       // image_total[75:44], zero[79:76]
	logic        m_tuser;  // is_total
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	image_tile_block_sum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	localparam int STALL_LIMIT = 5000;

	// pooling state mirrored by the testbench
	logic [IMG_REG_W-1:0]  img_rows_cfg;
	logic [IMG_REG_W-1:0]  img_cols_cfg;
	logic [TILE_REG_W-1:0] tile_rows_cfg;
	logic [TILE_REG_W-1:0] tile_cols_cfg;
	logic [SUM_W-1:0]      band_sum [TILES_ACROSS_DFLT];
	int unsigned           cur_row;
	int unsigned           cur_col;
	int unsigned           row_ofs;
	int unsigned           col_ofs;
	int unsigned           tile_col;
	logic [TOTAL_W-1:0]    brightness;
	int unsigned           images_closed;

	res_t sums_due [$];
	int   mismatches;
	int   stall_cycles;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   sink_hold;

	function automatic int unsigned side_limit(input int unsigned v, input int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	task automatic clear_image();
		foreach (band_sum[i]) begin
			band_sum[i] = '0;
		end
		cur_row    = 0;
		cur_col    = 0;
		row_ofs    = 0;
		col_ofs    = 0;
		tile_col   = 0;
		brightness = '0;
	endtask

	task automatic pool_pixel(input logic [7:0] px);
		int unsigned rows;
		int unsigned cols;
		int unsigned tr;
		int unsigned tc;
		int unsigned srow;
		int unsigned scol;
		bit          whole_r;
		bit          whole_c;
		bit          end_row;
		bit          end_img;
		res_t        r;
		rows    = side_limit(img_rows_cfg, MAX_IMAGE_SIDE);
		cols    = side_limit(img_cols_cfg, MAX_IMAGE_SIDE);
		tr      = side_limit(tile_rows_cfg, MAX_TILE_SIDE);
		tc      = side_limit(tile_cols_cfg, MAX_TILE_SIDE);
		srow    = cur_row - row_ofs;
		scol    = cur_col - col_ofs;
		whole_r = (srow + tr <= rows);
		whole_c = (tile_col < TILES_ACROSS_DFLT) && (scol + tc <= cols);
		end_row = (cur_col + 1 >= cols);
		end_img = end_row && (cur_row + 1 >= rows);
		brightness = brightness + px;
		if (whole_r && whole_c) begin
			band_sum[tile_col] = band_sum[tile_col] + px;
			if (row_ofs + 1 >= tr && col_ofs + 1 >= tc) begin
				r            = '0;
				r.center_row = COORD_W'(srow + tr / 2);
				r.center_col = COORD_W'(scol + tc / 2);
				r.tile_sum   = band_sum[tile_col];
				r.last       = !end_img;
				sums_due     = {sums_due, r};
				band_sum[tile_col] = '0;
			end
		end
		if (end_img) begin
			r             = '0;
			r.is_total    = 1'b1;
			r.image_total = brightness;
			r.last        = 1'b1;
			sums_due      = {sums_due, r};
			clear_image();
			images_closed++;
		end else if (end_row) begin
			cur_col  = 0;
			col_ofs  = 0;
			tile_col = 0;
			cur_row  = (cur_row + 1) & 12'hFFF;
			row_ofs  = (row_ofs + 1 >= tr) ? 0 : row_ofs + 1;
		end else begin
			cur_col = (cur_col + 1) & 12'hFFF;
			if (col_ofs + 1 >= tc) begin
				col_ofs = 0;
				if (tile_col < TILES_ACROSS_DFLT) begin
					tile_col++;
				end
			end else begin
				col_ofs++;
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_IMAGE_ROWS: img_rows_cfg  = IMG_REG_W'(val);
			REG_IMAGE_COLS: img_cols_cfg  = IMG_REG_W'(val);
			REG_TILE_ROWS:  tile_rows_cfg = TILE_REG_W'(val);
			REG_TILE_COLS:  tile_cols_cfg = TILE_REG_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_shape(input int unsigned rows, input int unsigned cols,
	                         input int unsigned trows, input int unsigned tcols);
		write_reg(REG_IMAGE_ROWS, rows);
		write_reg(REG_IMAGE_COLS, cols);
		write_reg(REG_TILE_ROWS, trows);
		write_reg(REG_TILE_COLS, tcols);
	endtask

	// valid stays high between back-to-back pixels
	task automatic send_pixel(input logic [7:0] px);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pool_pixel(px);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sums_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// level below zero: random pixels
	task automatic finish_image(input int level);
		int unsigned mark;
		mark = images_closed;
		while (images_closed == mark) begin
			send_pixel(level < 0 ? 8'($urandom) : 8'(level));
		end
	endtask

	task automatic test_defaults_mid_image();
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'($urandom));
		drain_results();
		write_reg(REG_IMAGE_ROWS, 2);
		write_reg(REG_IMAGE_COLS, 3);
		finish_image(-1);
		drain_results();
	endtask

	task automatic test_register_clamp();
		set_shape(0, 0, 0, 0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		drain_results();
		set_shape(8191, 2, 127, 2);
		repeat (4) send_pixel(8'($urandom));
		drain_results();
		write_reg(REG_IMAGE_ROWS, 2);
		finish_image(-1);
		drain_results();
	endtask

	task automatic test_tile_over_image();
		set_shape(2, 3, 3, 4);
		finish_image(-1);
		drain_results();
	endtask

	task automatic test_partial_strips();
		set_shape(3, 3, 2, 2);
		finish_image(-1);
		drain_results();
	endtask

	task automatic test_extremes();
		set_shape(64, 2, 64, 2);
		finish_image(255);
		drain_results();
		set_shape(2, 64, 2, 64);
		finish_image(-1);
		drain_results();
		set_shape(1, 70, 1, 1);
		finish_image(-1);
		drain_results();
	endtask

	task automatic test_back_pressure();
		set_shape(0, 0, 0, 0);
		@(posedge clk);
		sink_hold = 300;
		repeat (60) send_pixel(8'($urandom));
		drain_results();
	endtask

	task automatic set_random_shape();
		int unsigned rows;
		int unsigned cols;
		int unsigned trows;
		int unsigned tcols;
		drain_results();
		rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
		case ($urandom_range(0, 9))
			0:       cols = 0;
			1:       cols = $urandom_range(60, 80);
			default: cols = $urandom_range(1, 12);
		endcase
		case ($urandom_range(0, 9))
			0:       trows = 0;
			1:       trows = $urandom_range(65, 127);
			2:       trows = $urandom_range(5, 64);
			default: trows = $urandom_range(1, 4);
		endcase
		case ($urandom_range(0, 9))
			0:       tcols = 0;
			1:       tcols = $urandom_range(65, 127);
			2:       tcols = $urandom_range(5, 64);
			default: tcols = $urandom_range(1, 4);
		endcase
		set_shape(rows, cols, trows, tcols);
	endtask

	task automatic test_random_images(input int n_px);
		int          sent;
		int          cut;
		int unsigned mark;
		logic [1:0]  idx;
		sent = 0;
		while (sent < n_px) begin
			set_random_shape();
			cut  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 30)) : -1;
			mark = images_closed;
			while (images_closed == mark) begin
				if (cut == 0) begin
					// reshape part way through the image
					drain_results();
					idx = 2'($urandom_range(0, 3));
					write_reg(idx, (idx == REG_IMAGE_ROWS || idx == REG_IMAGE_COLS) ?
					          $urandom_range(0, 12) : $urandom_range(0, 6));
				end
				send_pixel(8'($urandom));
				sent++;
				cut--;
			end
		end
		drain_results();
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
				         $time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = sums_due.pop_front();
				check_field("is_total", want.is_total, m_tuser);
				check_field("center_row", want.center_row, m_tdata[11:0]);
				check_field("center_col", want.center_col, m_tdata[23:12]);
				check_field("tile_sum", want.tile_sum, m_tdata[43:24]);
				check_field("image_total", want.image_total, m_tdata[75:44]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		mismatches    = 0;
		stall_cycles  = 0;
		sink_hold     = 0;
		images_closed = 0;
		img_rows_cfg  = IMAGE_ROWS_RST;
		img_cols_cfg  = IMAGE_COLS_RST;
		tile_rows_cfg = TILE_ROWS_RST;
		tile_cols_cfg = TILE_COLS_RST;
		clear_image();
		src_idle_pct  = 15;
		snk_idle_pct  = 76;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults_mid_image();
		test_register_clamp();
		test_tile_over_image();
		test_partial_strips();
		test_random_images(250);

		src_idle_pct = 76;
		snk_idle_pct = 15;
		test_extremes();
		test_random_images(250);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_back_pressure();
		test_random_images(250);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && sums_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
